// ----- rtl/nfste_pkg.sv -----
// shared types, constants and a helper function for the nearest-first table emitter
// no dependencies; used by nfste_ctrl, nfste_dp and the top level
`default_nettype none

package nfste_pkg;

   // field widths
   localparam int POS_W           = 32;
   localparam int IDX_W           = 6;
   localparam int CNT_W           = 7;
   localparam int DIST_W          = POS_W + 1;
   localparam int TABLE_DEPTH_DEF = 64;

   // item kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // table read address sources
   typedef enum logic [2:0] {
      RD_MID,
      RD_LO,
      RD_LO_M1,
      RD_LO_M2,
      RD_TAKE
   } rd_sel_type;

   // commands from controller to datapath
   typedef struct packed {
      logic       write_en;
      logic       start;
      logic       search_upd;
      logic       load_right;
      logic       load_left;
      logic       pick_lower;
      logic       pick_upper;
      logic       emit;
      logic       emit_empty;
      rd_sel_type rd_sel;
   } nfste_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic n_zero;
      logic lo_lt_hi;
      logic lo_zero;
      logic lo_one;
      logic left_closer;
      logic take_left;
      logic more_left;
      logic more_right;
      logic last;
      logic out_free;
   } nfste_stat_type;

   // absolute distance of two positions at 33 bits
   function automatic logic [DIST_W-1:0] dist33(input logic signed [POS_W-1:0] a,
                                                input logic signed [POS_W-1:0] b);
      logic signed [DIST_W-1:0] d;
      d = DIST_W'(a) - DIST_W'(b);
      if (d < 0) begin
         d = -d;
      end
      return DIST_W'(unsigned'(d));
   endfunction

endpackage

`default_nettype wire

// ----- rtl/nfste_ctrl.sv -----
// controller state machine: binary search, closest pick and outward walk sequencing
// depends on nfste_pkg for the command and status structs
`default_nettype none

module nfste_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_kind,
   output logic                         req_stall,
   input  wire nfste_pkg::nfste_stat_type stat,
   output nfste_pkg::nfste_cmd_type     cmd
);
   import nfste_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_SEARCH = 10'b0000000010,
      ST_SCMP   = 10'b0000000100,
      ST_CLO1   = 10'b0000001000,
      ST_CLO2   = 10'b0000010000,
      ST_CLO3   = 10'b0000100000,
      ST_EMIT   = 10'b0001000000,
      ST_LFETCH = 10'b0010000000,
      ST_RFETCH = 10'b0100000000,
      ST_EMPTY  = 10'b1000000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // items are taken only between queries
   assign req_stall = (state_ff != ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel = RD_LO;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == KIND_QUERY) begin
                  cmd.start = 1'b1;
                  state_in  = ST_SEARCH;
               end else begin
                  cmd.write_en = 1'b1;
               end
            end
         end
         ST_SEARCH: begin
            if (stat.n_zero) begin
               state_in = ST_EMPTY;
            end else if (stat.lo_lt_hi) begin
               cmd.rd_sel = RD_MID;
               state_in   = ST_SCMP;
            end else begin
               cmd.rd_sel = RD_LO;
               state_in   = ST_CLO1;
            end
         end
         ST_SCMP: begin
            cmd.search_upd = 1'b1;
            state_in       = ST_SEARCH;
         end
         ST_CLO1: begin
            // table[lo] arrives; fetch its lower neighbour if there is one
            cmd.load_right = 1'b1;
            cmd.rd_sel     = RD_LO_M1;
            if (stat.lo_zero) begin
               cmd.pick_upper = 1'b1;
               state_in       = ST_EMIT;
            end else begin
               state_in = ST_CLO2;
            end
         end
         ST_CLO2: begin
            cmd.load_left = 1'b1;
            state_in      = ST_CLO3;
         end
         ST_CLO3: begin
            // tie goes to the lower entry
            if (stat.left_closer) begin
               cmd.pick_lower = 1'b1;
               cmd.rd_sel     = RD_LO_M2;
               state_in       = stat.lo_one ? ST_EMIT : ST_LFETCH;
            end else begin
               cmd.pick_upper = 1'b1;
               state_in       = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.rd_sel = RD_TAKE;
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (stat.last) begin
                  state_in = ST_IDLE;
               end else if (stat.take_left) begin
                  state_in = stat.more_left ? ST_LFETCH : ST_EMIT;
               end else begin
                  state_in = stat.more_right ? ST_RFETCH : ST_EMIT;
               end
            end
         end
         ST_LFETCH: begin
            cmd.load_left = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_RFETCH: begin
            cmd.load_right = 1'b1;
            state_in       = ST_EMIT;
         end
         ST_EMPTY: begin
            if (stat.out_free) begin
               cmd.emit_empty = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/nfste_dp.sv -----
// datapath: position table memory, search bounds, walk pointers, distances and result register
// depends on nfste_pkg for widths, command and status structs and the distance function
`default_nettype none

module nfste_dp #(
   parameter int TABLE_DEPTH = nfste_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire nfste_pkg::nfste_cmd_type          cmd,
   output nfste_pkg::nfste_stat_type              stat,
   input  wire logic [nfste_pkg::IDX_W-1:0]       req_slot,
   input  wire logic signed [nfste_pkg::POS_W-1:0] req_position,
   input  wire logic                              csr_write,
   input  wire logic [nfste_pkg::CNT_W-1:0]       csr_table_count,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [nfste_pkg::POS_W-1:0]     rsp_entry_position,
   output logic [nfste_pkg::IDX_W-1:0]            rsp_entry_index,
   output logic                                   rsp_empty_res,
   output logic                                   rsp_last
);
   import nfste_pkg::*;

   localparam int               ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

   // table memory and registered read data
   logic signed [POS_W-1:0] table_ff [TABLE_DEPTH];
   logic signed [POS_W-1:0] rdata_ff;
   logic [CNT_W-1:0]        rd_ptr;

   // configuration and query registers
   logic [CNT_W-1:0]        count_ff;
   logic signed [POS_W-1:0] target_ff, target_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic [CNT_W-1:0]        lo_ff, lo_in;
   logic [CNT_W-1:0]        hi_ff, hi_in;
   logic [CNT_W-1:0]        lb_ff, lb_in;   // left pointer plus one, zero when exhausted
   logic [CNT_W-1:0]        r_ff, r_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [POS_W-1:0] lv_ff, lv_in;
   logic signed [POS_W-1:0] rv_ff, rv_in;
   logic [DIST_W-1:0]       dl_ff, dl_in;
   logic [DIST_W-1:0]       dr_ff, dr_in;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [POS_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic [IDX_W-1:0]        rsp_idx_ff, rsp_idx_in;
   logic                    rsp_empty_ff, rsp_empty_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [CNT_W-1:0]        mid;
   logic [CNT_W-1:0]        n_clamp;
   logic [DIST_W-1:0]       dist_rd;
   logic                    left_ok;
   logic                    right_ok;
   logic                    take_left;

   assign mid      = (lo_ff + hi_ff) >> 1;
   assign n_clamp  = (count_ff > DEPTH_C) ? DEPTH_C : count_ff;
   assign dist_rd  = dist33(rdata_ff, target_ff);
   assign left_ok  = (lb_ff != '0);
   assign right_ok = (r_ff < n_ff);
   assign take_left = left_ok && (!right_ok || (dl_ff <= dr_ff));

   // status towards the controller
   always_comb begin
      stat.n_zero      = (n_ff == '0);
      stat.lo_lt_hi    = (lo_ff < hi_ff);
      stat.lo_zero     = (lo_ff == '0);
      stat.lo_one      = (lo_ff == CNT_W'(1));
      stat.left_closer = (dl_ff <= dr_ff);
      stat.take_left   = take_left;
      stat.more_left   = (lb_ff >= CNT_W'(2));
      stat.more_right  = ((r_ff + CNT_W'(1)) < n_ff);
      stat.last        = ((cnt_ff + CNT_W'(1)) == n_ff);
      stat.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   // read address selection
   always_comb begin
      case (cmd.rd_sel)
         RD_MID:   rd_ptr = mid;
         RD_LO:    rd_ptr = lo_ff;
         RD_LO_M1: rd_ptr = lo_ff - CNT_W'(1);
         RD_LO_M2: rd_ptr = lo_ff - CNT_W'(2);
         RD_TAKE:  rd_ptr = take_left ? (lb_ff - CNT_W'(2)) : (r_ff + CNT_W'(1));
         default:  rd_ptr = lo_ff;
      endcase
   end

   // table write and registered read
   always_ff @(posedge clock) begin
      if (cmd.write_en && ({1'b0, req_slot} < DEPTH_C)) begin
         table_ff[req_slot[ADDR_W-1:0]] <= req_position;
      end
      rdata_ff <= table_ff[rd_ptr[ADDR_W-1:0]];
   end

   // search, pick and walk updates
   always_comb begin
      target_in    = target_ff;
      n_in         = n_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      lb_in        = lb_ff;
      r_in         = r_ff;
      cnt_in       = cnt_ff;
      lv_in        = lv_ff;
      rv_in        = rv_ff;
      dl_in        = dl_ff;
      dr_in        = dr_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.start) begin
         target_in = req_position;
         n_in      = n_clamp;
         lo_in     = '0;
         hi_in     = n_clamp - CNT_W'(1);
         cnt_in    = '0;
      end
      // lower bound step
      if (cmd.search_upd) begin
         if (rdata_ff < target_ff) begin
            lo_in = mid + CNT_W'(1);
         end else begin
            hi_in = mid;
         end
      end
      if (cmd.load_right) begin
         rv_in = rdata_ff;
         dr_in = dist_rd;
      end
      if (cmd.load_left) begin
         lv_in = rdata_ff;
         dl_in = dist_rd;
      end
      // closest is the entry below the lower bound
      if (cmd.pick_lower) begin
         r_in  = lo_ff - CNT_W'(1);
         rv_in = lv_ff;
         dr_in = dl_ff;
         lb_in = lo_ff - CNT_W'(1);
      end
      if (cmd.pick_upper) begin
         r_in  = lo_ff;
         lb_in = lo_ff;
      end
      // emit the nearer side and step its pointer outward
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_empty_in = 1'b0;
         rsp_last_in  = stat.last;
         cnt_in       = cnt_ff + CNT_W'(1);
         if (take_left) begin
            rsp_pos_in = lv_ff;
            rsp_idx_in = IDX_W'(lb_ff - CNT_W'(1));
            lb_in      = lb_ff - CNT_W'(1);
         end else begin
            rsp_pos_in = rv_ff;
            rsp_idx_in = IDX_W'(r_ff);
            r_in       = r_ff + CNT_W'(1);
         end
      end
      if (cmd.emit_empty) begin
         rsp_valid_in = 1'b1;
         rsp_pos_in   = '0;
         rsp_idx_in   = '0;
         rsp_empty_in = 1'b1;
         rsp_last_in  = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         target_ff    <= '0;
         n_ff         <= '0;
         lo_ff        <= '0;
         hi_ff        <= '0;
         lb_ff        <= '0;
         r_ff         <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            count_ff <= csr_table_count;
         end
         target_ff    <= target_in;
         n_ff         <= n_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         lb_ff        <= lb_in;
         r_ff         <= r_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lv_ff        <= lv_in;
      rv_ff        <= rv_in;
      dl_ff        <= dl_in;
      dr_ff        <= dr_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_entry_position = rsp_pos_ff;
   assign rsp_entry_index    = rsp_idx_ff;
   assign rsp_empty_res      = rsp_empty_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

`default_nettype wire

// ----- rtl/nearest_first_sorted_table_emitter.sv -----
// top level of the nearest-first table emitter: joins nfste_ctrl and nfste_dp (uses nfste_pkg)
// a write item is taken while idle; a query blocks further items until its last result is emitted,
// and its walk is paced by the one table read port (one fetch per result) and by rsp_stall
// synchronous active-high reset clears the controller, the pointers, table_count and the result
// valid flag; the table contents are not cleared and need no clearing pass
`default_nettype none

module nearest_first_sorted_table_emitter #(
   parameter int TABLE_DEPTH = nfste_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_kind,
   input  wire logic [nfste_pkg::IDX_W-1:0]        req_slot,
   input  wire logic signed [nfste_pkg::POS_W-1:0] req_position,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [nfste_pkg::POS_W-1:0]      rsp_entry_position,
   output logic [nfste_pkg::IDX_W-1:0]             rsp_entry_index,
   output logic                                    rsp_empty_res,
   output logic                                    rsp_last,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [nfste_pkg::CNT_W-1:0]        csr_table_count
);
   import nfste_pkg::*;

   nfste_cmd_type  cmd;
   nfste_stat_type stat;

   // register write always taken
   assign csr_ready = 1'b1;

   nfste_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   nfste_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_slot           (req_slot),
      .req_position       (req_position),
      .csr_write          (csr_valid && csr_ready),
      .csr_table_count    (csr_table_count),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_entry_position (rsp_entry_position),
      .rsp_entry_index    (rsp_entry_index),
      .rsp_empty_res      (rsp_empty_res),
      .rsp_last           (rsp_last)
   );

`ifndef NO_ASSERTIONS
   // a query item blocks further items while it is worked on
   a_query_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_kind == KIND_QUERY) |=> req_stall)
      else $error("query item did not block the input");

   // a write item leaves the block ready for the next item
   a_write_no_block: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_kind == KIND_WRITE) |=> !req_stall)
      else $error("write item blocked the input");

   // an empty-table item is the only and last result of its query
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> rsp_last)
      else $error("empty-table item not flagged last");

   // an empty-table item carries zero position and index
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> (rsp_entry_index == '0) && (rsp_entry_position == '0))
      else $error("empty-table item carries data");
`endif

endmodule

`default_nettype wire
